[rtl/thse_pkg.sv]
`timescale 1ns / 1ps

package thse_pkg;

  // Fraction bits of the coordinates and of every result.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int CW   = 18;   // one coordinate
  localparam int NW   = 4;    // node number
  localparam int OW   = 24;   // one result word
  localparam int ORDW = 2;    // order register

  localparam int IN_TDATA_W  = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NW + 4 * OW + 7) / 8) * 8;

  // Doubled barycentric coordinate, exact.
  localparam int LW  = ((FRAC_BITS + 2 > CW) ? FRAC_BITS + 2 : CW) + 2;
  localparam int PW  = 2 * LW;                    // li*lj
  localparam int PRW = PW + 1 - (FRAC_BITS + 2);  // li*lj after rounding
  localparam int SW  = LW + 1;                    // li*dlj + dli*lj

  // Edge scale -2*sqrt(3/2) with 20 fraction bits.
  localparam int C0_FIXED = -2568476;
  localparam int C0_FRAC  = 20;
  localparam int C0W      = 23;
  localparam int GMW      = C0W + SW;
  localparam int VMW      = C0W + PRW;

  // Working width for rounding and clipping.
  localparam int SATW = 64;

  localparam logic signed [C0W-1:0]  C0_S  = C0W'(C0_FIXED);
  localparam logic signed [LW-1:0]   ONE_L = LW'(1) << FRAC_BITS;
  localparam logic signed [SATW-1:0] HALF  = SATW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SATW-1:0] RND_P = SATW'(1) << (FRAC_BITS + 1);
  localparam logic signed [SATW-1:0] RND_V = SATW'(1) << (C0_FRAC - 1);
  localparam logic signed [SATW-1:0] RND_G = SATW'(1) << (C0_FRAC + 1);
  localparam logic signed [SATW-1:0] OUT_MAX = SATW'((1 << (OW - 1)) - 1);
  localparam logic signed [SATW-1:0] OUT_MIN = -SATW'(1 << (OW - 1));

  // Node numbers.
  localparam logic [NW-1:0] NODE_V0  = 4'd0;
  localparam logic [NW-1:0] NODE_V1  = 4'd1;
  localparam logic [NW-1:0] NODE_V2  = 4'd2;
  localparam logic [NW-1:0] NODE_V3  = 4'd3;
  localparam logic [NW-1:0] NODE_E01 = 4'd4;
  localparam logic [NW-1:0] NODE_E12 = 4'd5;
  localparam logic [NW-1:0] NODE_E20 = 4'd6;
  localparam logic [NW-1:0] NODE_E03 = 4'd7;
  localparam logic [NW-1:0] NODE_E13 = 4'd8;
  localparam logic [NW-1:0] NODE_E23 = 4'd9;

  typedef struct packed {
    logic [NW-1:0]          node;
    logic                   last;
    logic                   is_edge;
    logic signed [LW-1:0]   la;
    logic signed [LW-1:0]   lb;
  } s1_t;

  typedef struct packed {
    logic [NW-1:0]          node;
    logic                   last;
    logic                   is_edge;
    logic signed [PW-1:0]   prod;
    logic [2:0][SW-1:0]     sum;
    logic signed [OW-1:0]   vval;
  } s2_t;

  typedef struct packed {
    logic [NW-1:0]          node;
    logic                   last;
    logic                   is_edge;
    logic signed [PRW-1:0]  prnd;
    logic [2:0][GMW-1:0]    gm;
    logic signed [OW-1:0]   vval;
  } s3_t;

  typedef struct packed {
    logic [NW-1:0]          node;
    logic                   last;
    logic                   is_edge;
    logic signed [VMW-1:0]  vm;
    logic [2:0][OW-1:0]     grad;
    logic signed [OW-1:0]   vval;
  } s4_t;

  typedef struct packed {
    logic [NW-1:0]          node;
    logic                   last;
    logic signed [OW-1:0]   value;
    logic [2:0][OW-1:0]     grad;
  } res_t;

  function automatic logic signed [OW-1:0] sat_out(input logic signed [SATW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > OUT_MAX) begin
      r = OW'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OW'(OUT_MIN);
    end else begin
      r = OW'(v);
    end
    return r;
  endfunction

  // First vertex of a node; a vertex node is its own vertex.
  function automatic logic [1:0] node_a(input logic [NW-1:0] node);
    logic [1:0] v;
    unique case (node)
      NODE_V0, NODE_E01, NODE_E03: v = 2'd0;
      NODE_V1, NODE_E12, NODE_E13: v = 2'd1;
      NODE_V2, NODE_E20, NODE_E23: v = 2'd2;
      NODE_V3:                     v = 2'd3;
      default:                     v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] node_b(input logic [NW-1:0] node);
    logic [1:0] v;
    unique case (node)
      NODE_E01:                    v = 2'd1;
      NODE_E12:                    v = 2'd2;
      NODE_E20:                    v = 2'd0;
      NODE_E03, NODE_E13, NODE_E23: v = 2'd3;
      default:                     v = node[1:0];
    endcase
    return v;
  endfunction

  // Gradient of a doubled barycentric coordinate: -1, 0 or +1.
  function automatic logic signed [1:0] grad_coef(input logic [1:0] vtx,
                                                  input logic [1:0] comp);
    logic signed [1:0] k;
    if (vtx == 2'd0) begin
      k = -2'sd1;
    end else if (vtx - 2'd1 == comp) begin
      k = 2'sd1;
    end else begin
      k = 2'sd0;
    end
    return k;
  endfunction

  function automatic logic signed [SW-1:0] scale_term(input logic signed [LW-1:0] l,
                                                      input logic signed [1:0] k);
    logic signed [SW-1:0] r;
    unique case (k)
      2'sd1:   r = SW'(l);
      -2'sd1:  r = -SW'(l);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/tet_hierarchic_shape_eval.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   one point (r, s, t)
// m_axis    out  m_axis_tvalid/m_axis_tready   one node result, tlast on the final node
// cfg       in   cfg_valid_i/cfg_ready_o       polynomial order
//
// A point yields one result per cycle while the pipeline is not stalled: 4 at orders 0
// and 1, 10 at orders 2 and 3, from the node sequencer that issues one node per cycle.
// A result passes through five register stages from issue to m_axis; the last stage is
// the output register.
// Reset clears the valid bits, the sequencer and sets the order to 1.
// On an m_axis stall a valid stage holds only if every later stage is valid; s_axis takes
// the next point in the cycle that the current point issues its final node.

module tet_hierarchic_shape_eval
  import thse_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // coord_r, coord_s, coord_t, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // node_index, shape_value, grad_r, grad_s, grad_t, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ORDW-1:0]        cfg_data_i
);

  logic [ORDW-1:0] order_q;

  // Sequencer
  logic                  busy_q, busy_d;
  logic [NW-1:0]         node_q, node_d;
  logic                  edges_q, edges_d;
  logic signed [CW-1:0]  r_q, s_q, t_q;
  logic                  seq_last, issue, in_acc;

  // Pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  res_t o_q, o_d;

  logic signed [LW-1:0]   lbar [4];
  logic [1:0]             va2, vb2;
  logic signed [SATW-1:0] vtmp, ptmp, mtmp;
  logic signed [SATW-1:0] gtmp [3];
  logic signed [1:0]      k5;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDW'(1);
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i;
    end
  end

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign seq_last      = edges_q ? (node_q == NODE_E23) : (node_q == NODE_V3);
  assign issue         = busy_q && rdy1;
  assign s_axis_tready = !busy_q || (issue && seq_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    busy_d  = busy_q;
    node_d  = node_q;
    edges_d = edges_q;
    if (issue) begin
      if (seq_last) begin
        busy_d = 1'b0;
      end else begin
        node_d = node_q + NW'(1);
      end
    end
    if (in_acc) begin
      busy_d  = 1'b1;
      node_d  = NODE_V0;
      // Orders 2 and 3 both add the edge nodes.
      edges_d = order_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      node_q  <= NODE_V0;
      edges_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      node_q  <= node_d;
      edges_q <= edges_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q <= s_axis_tdata[CW-1:0];
      s_q <= s_axis_tdata[2*CW-1:CW];
      t_q <= s_axis_tdata[3*CW-1:2*CW];
    end
  end

  // Stage 1: doubled barycentric coordinates of the node's two vertices.
  always_comb begin
    lbar[1] = LW'(r_q) + ONE_L;
    lbar[2] = LW'(s_q) + ONE_L;
    lbar[3] = LW'(t_q) + ONE_L;
    lbar[0] = -(LW'(r_q) + LW'(s_q) + LW'(t_q) + ONE_L);
    s1_d.node    = node_q;
    s1_d.last    = seq_last;
    s1_d.is_edge = edges_q && (node_q >= NODE_E01);
    s1_d.la      = lbar[node_a(node_q)];
    s1_d.lb      = lbar[node_b(node_q)];
  end

  // Stage 2: li*lj, gradient sums and the vertex value.
  always_comb begin
    va2 = node_a(s1_q.node);
    vb2 = node_b(s1_q.node);
    s2_d.node    = s1_q.node;
    s2_d.last    = s1_q.last;
    s2_d.is_edge = s1_q.is_edge;
    s2_d.prod    = PW'(s1_q.la) * PW'(s1_q.lb);
    for (int c = 0; c < 3; c++) begin
      s2_d.sum[c] = scale_term(s1_q.la, grad_coef(vb2, 2'(c)))
                  + scale_term(s1_q.lb, grad_coef(va2, 2'(c)));
    end
    vtmp      = SATW'(s1_q.la) + SATW'(1);
    s2_d.vval = sat_out(vtmp >>> 1);
  end

  // Stage 3: round li*lj, scale the gradient sums.
  always_comb begin
    s3_d.node    = s2_q.node;
    s3_d.last    = s2_q.last;
    s3_d.is_edge = s2_q.is_edge;
    s3_d.vval    = s2_q.vval;
    ptmp         = SATW'(s2_q.prod) + RND_P;
    s3_d.prnd    = PRW'(ptmp >>> (FRAC_BITS + 2));
    for (int c = 0; c < 3; c++) begin
      s3_d.gm[c] = GMW'(C0_S) * GMW'($signed(s2_q.sum[c]));
    end
  end

  // Stage 4: scale the value, round and clip the gradients.
  always_comb begin
    s4_d.node    = s3_q.node;
    s4_d.last    = s3_q.last;
    s4_d.is_edge = s3_q.is_edge;
    s4_d.vval    = s3_q.vval;
    s4_d.vm      = VMW'(C0_S) * VMW'(s3_q.prnd);
    for (int c = 0; c < 3; c++) begin
      gtmp[c]      = SATW'($signed(s3_q.gm[c])) + RND_G;
      s4_d.grad[c] = sat_out(gtmp[c] >>> (C0_FRAC + 2));
    end
  end

  // Stage 5: round the edge value and pick the vertex or edge result.
  always_comb begin
    mtmp       = SATW'(s4_q.vm) + RND_V;
    o_d.node   = s4_q.node;
    o_d.last   = s4_q.last;
    k5         = 2'sd0;
    if (s4_q.is_edge) begin
      o_d.value = sat_out(mtmp >>> C0_FRAC);
      o_d.grad  = s4_q.grad;
    end else begin
      o_d.value = s4_q.vval;
      for (int c = 0; c < 3; c++) begin
        k5 = grad_coef(s4_q.node[1:0], 2'(c));
        unique case (k5)
          2'sd1:   o_d.grad[c] = sat_out(HALF);
          -2'sd1:  o_d.grad[c] = sat_out(-HALF);
          default: o_d.grad[c] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= busy_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
    if (rdy5) o_q  <= o_d;
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tlast  = o_q.last;
  assign m_axis_tdata  = {(OUT_TDATA_W - NW - 4 * OW)'(0),
                          o_q.grad[2], o_q.grad[1], o_q.grad[0],
                          o_q.value, o_q.node};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import thse_pkg::*;

  localparam int    WATCHDOG_LIMIT = 3000;
  localparam longint EDGE_SCALE    = -2568476;  // -2*sqrt(3/2), 20 fraction bits
  localparam int    EDGE_SCALE_FRAC = 20;

  typedef struct {
    logic [NW-1:0] node;
    logic [OW-1:0] value;
    logic [OW-1:0] grad_r;
    logic [OW-1:0] grad_s;
    logic [OW-1:0] grad_t;
    logic          last;
  } node_result_t;

  // Shape function predictor and the queue of node results still owed by the block.
  class shape_scoreboard;
    node_result_t owed[$];
    logic [ORDW-1:0] order = 2'd1;
    int errors = 0;
    int points = 0;
    int checked = 0;
    int edge_a[6] = '{0, 1, 2, 0, 1, 2};
    int edge_b[6] = '{1, 2, 0, 3, 3, 3};
    logic [NW-1:0] vtx_node[4] = '{NODE_V0, NODE_V1, NODE_V2, NODE_V3};
    logic [NW-1:0] edge_node[6] = '{NODE_E01, NODE_E12, NODE_E20,
                                    NODE_E03, NODE_E13, NODE_E23};

    // Round to nearest with ties toward +infinity; the shift floors.
    function longint round_up_half(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function logic [OW-1:0] clip(longint v);
      if (v > longint'(8388607)) return 24'h7FFFFF;
      if (v < longint'(-8388608)) return 24'h800000;
      return v[OW-1:0];
    endfunction

    // Slope of a doubled barycentric coordinate along one axis.
    function longint slope(int vtx, int axis);
      if (vtx == 0) return -1;
      return (vtx - 1 == axis) ? 1 : 0;
    endfunction

    function void note_point(logic signed [CW-1:0] r, logic signed [CW-1:0] s,
                             logic signed [CW-1:0] t);
      longint one;
      longint lv[4];
      longint g[3];
      longint prod;
      longint val;
      bit with_edges;
      node_result_t res;
      one = longint'(1) <<< FRAC_BITS;
      with_edges = (order >= 2'd2);
      lv[0] = -(longint'(r) + longint'(s) + longint'(t) + one);
      lv[1] = longint'(r) + one;
      lv[2] = longint'(s) + one;
      lv[3] = longint'(t) + one;
      points++;
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 3; c++) g[c] = slope(i, c) * (one / 2);
        res.node   = vtx_node[i];
        res.value  = clip(round_up_half(lv[i], 1));
        res.grad_r = clip(g[0]);
        res.grad_s = clip(g[1]);
        res.grad_t = clip(g[2]);
        res.last   = !with_edges && (i == 3);
        owed.insert(owed.size(), res);
      end
      if (with_edges) begin
        for (int e = 0; e < 6; e++) begin
          int a;
          int b;
          a = edge_a[e];
          b = edge_b[e];
          prod = round_up_half(lv[a] * lv[b], FRAC_BITS + 2);
          val  = round_up_half(EDGE_SCALE * prod, EDGE_SCALE_FRAC);
          for (int c = 0; c < 3; c++) begin
            g[c] = round_up_half(EDGE_SCALE * (lv[a] * slope(b, c) + lv[b] * slope(a, c)),
                                 EDGE_SCALE_FRAC + 2);
          end
          res.node   = edge_node[e];
          res.value  = clip(val);
          res.grad_r = clip(g[0]);
          res.grad_s = clip(g[1]);
          res.grad_t = clip(g[2]);
          res.last   = (e == 5);
          owed.insert(owed.size(), res);
        end
      end
    endfunction

    function void compare_field(string name, logic [NW-1:0] node, logic [OW-1:0] exp_v,
                                logic [OW-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: node %0d %s mismatch, expected %h, got %h",
                 $time, node, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic last);
      node_result_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected node result, expected none, got tdata %h tlast %b",
                 $time, d, last);
        return;
      end
      exp_r = owed.pop_front();
      checked++;
      compare_field("node_index", exp_r.node, OW'(exp_r.node), OW'(d[NW-1:0]));
      compare_field("shape_value", exp_r.node, exp_r.value, d[NW +: OW]);
      compare_field("grad_r", exp_r.node, exp_r.grad_r, d[NW + OW +: OW]);
      compare_field("grad_s", exp_r.node, exp_r.grad_s, d[NW + 2 * OW +: OW]);
      compare_field("grad_t", exp_r.node, exp_r.grad_t, d[NW + 3 * OW +: OW]);
      compare_field("last_node", exp_r.node, OW'(exp_r.last), OW'(last));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [ORDW-1:0]        cfg_data_i = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  shape_scoreboard sb = new;

  tet_hierarchic_shape_eval dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random back-pressure and checking of every accepted node result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles, %0d node results still owed",
             $time, WATCHDOG_LIMIT, sb.owed.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_point(logic signed [CW-1:0] r, logic signed [CW-1:0] s,
                            logic signed [CW-1:0] t);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({t, s, r});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_point(r, s, t);
  endtask

  // Lets every owed result come out, then waits for the pipeline to settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_order(logic [ORDW-1:0] order);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= order;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.order = order;
  endtask

  // Mostly coordinates in [-1, 1], some at the extremes, some any pattern.
  function automatic logic signed [CW-1:0] rand_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return CW'($urandom);
    if (pick == 1) begin
      unique case ($urandom_range(4))
        0: return -CW'(131072);
        1: return CW'(131071);
        2: return -CW'(65536);
        3: return CW'(65536);
        default: return '0;
      endcase
    end
    return CW'(int'($urandom_range(131072)) - 65536);
  endfunction

  initial begin : stimulus
    logic [ORDW-1:0] phase_order[8];
    int gap_by_mode[4];
    int stall_by_mode[4];
    phase_order   = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd3};
    gap_by_mode   = '{0, 58, 0, 31};
    stall_by_mode = '{0, 0, 58, 31};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Order 1 out of reset: origin, the four vertices and the far corner.
    send_point(0, 0, 0);
    send_point(-65536, -65536, -65536);
    send_point(65536, -65536, -65536);
    send_point(-65536, 65536, -65536);
    send_point(-65536, -65536, 65536);
    send_point(-131072, -131072, -131072);
    drain_results();

    write_order(2'd2);
    send_point(131071, 131071, 131071);
    send_point(-131072, -131072, -131072);
    send_point(-131072, 131071, -131072);
    send_point(131071, -131072, 131071);
    send_point(-65536, -65536, -65536);
    send_point(65536, -65536, -65536);
    send_point(-65536, 65536, -65536);
    send_point(-65536, -65536, 65536);
    send_point(-32768, -32768, -32768);
    send_point(-1, -1, -1);
    send_point(1, 0, -1);
    send_point(0, -65536, -65536);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      write_order(phase_order[p]);
      gap_pct   = gap_by_mode[p % 4];
      stall_pct = stall_by_mode[p % 4];
      repeat (24) send_point(rand_coord(), rand_coord(), rand_coord());
      drain_results();
    end

    $display("Sent %0d points over orders 0 to 3 and four pacing modes;", sb.points);
    $display("checked %0d node results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/thse_pkg.sv
rtl/tet_hierarchic_shape_eval.sv
tb/tb.sv
